/* hw/rtl/bounded_queue_reverse_find_macros.svh */
// ----------------------------------------------------------------------------
// Bounded queue assertion macros
// Concurrent assertion helpers used by the bounded queue top level.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_QUEUE_REVERSE_FIND_MACROS_SVH
`define BOUNDED_QUEUE_REVERSE_FIND_MACROS_SVH

`ifndef ASSERT_OFF
`define BQRF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bounded queue assertion failed");
`define BQRF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bounded queue assertion failed");
`else
`define BQRF_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define BQRF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* hw/rtl/bqrf_pkg.sv */
// ----------------------------------------------------------------------------
// Bounded queue package
// Shared constants, codes and controller to datapath types.
// ----------------------------------------------------------------------------
package bqrf_pkg;

   localparam int DEPTH_DEFAULT = 128;
   localparam int VALUE_W       = 32;
   localparam int FIELD_W       = 8;

   typedef enum logic [1:0] {
      FUNC_PUSH    = 2'd0,
      FUNC_POP     = 2'd1,
      FUNC_REVERSE = 2'd2,
      FUNC_FIND    = 2'd3
   } func_type;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_SCAN,
      ST_FIND_DONE
   } state_type;

   typedef enum logic [1:0] {
      RSP_NOW,
      RSP_POP,
      RSP_FIND
   } rsp_sel_type;

   typedef struct packed {
      logic        accept;
      logic        find_start;
      logic        scan_step;
      logic        find_end;
      logic        load_rsp;
      rsp_sel_type rsp_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic empty;
      logic match;
      logic last;
   } dp_status_type;

endpackage

/* hw/rtl/bqrf_ctrl.sv */
// ----------------------------------------------------------------------------
// Bounded queue controller
// Sequences one request word at a time and owns the result valid flag.
// ----------------------------------------------------------------------------
module bqrf_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [1:0]               req_func,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  bqrf_pkg::dp_status_type  dp_status,
   output bqrf_pkg::dp_cmd_type     dp_cmd
);
   import bqrf_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;
   logic      accept;
   func_type  func;

   assign func      = func_type'(req_func);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (func == FUNC_POP && !dp_status.empty) begin
                  state_in = ST_POP;
               end else if (func == FUNC_FIND && !dp_status.empty) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_POP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (dp_status.match || dp_status.last) begin
               state_in = ST_FIND_DONE;
            end
         end
         ST_FIND_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      dp_cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            dp_cmd.accept = accept;
            if (accept) begin
               priority if (func == FUNC_POP && !dp_status.empty) begin
                  dp_cmd.load_rsp = 1'b0;
               end else if (func == FUNC_FIND && !dp_status.empty) begin
                  dp_cmd.find_start = 1'b1;
               end else begin
                  dp_cmd.load_rsp = 1'b1;
                  dp_cmd.rsp_sel  = RSP_NOW;
               end
            end
         end
         ST_POP: begin
            dp_cmd.load_rsp = out_free;
            dp_cmd.rsp_sel  = RSP_POP;
         end
         ST_SCAN: begin
            if (dp_status.match || dp_status.last) begin
               dp_cmd.find_end = 1'b1;
            end else begin
               dp_cmd.scan_step = 1'b1;
            end
         end
         ST_FIND_DONE: begin
            dp_cmd.load_rsp = out_free;
            dp_cmd.rsp_sel  = RSP_FIND;
         end
      endcase
   end

   assign rsp_valid_in = dp_cmd.load_rsp || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hw/rtl/bqrf_dp.sv */
// ----------------------------------------------------------------------------
// Bounded queue datapath
// Ring memory with head and tail pointers, direction flag, search scan and
// the result word register.
// ----------------------------------------------------------------------------
module bqrf_dp #(
   parameter int DEPTH = bqrf_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [1:0]                        req_func,
   input  logic signed [bqrf_pkg::VALUE_W-1:0] req_value,
   input  bqrf_pkg::dp_cmd_type              dp_cmd,
   output bqrf_pkg::dp_status_type           dp_status,
   output logic [1:0]                        rsp_status,
   output logic signed [bqrf_pkg::VALUE_W-1:0] rsp_popped,
   output logic                              rsp_found,
   output logic [bqrf_pkg::FIELD_W-1:0]      rsp_position,
   output logic [bqrf_pkg::FIELD_W-1:0]      rsp_count,
   output logic                              rsp_is_full,
   output logic                              rsp_is_empty
);
   import bqrf_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = CW + FIELD_W;

   logic [VALUE_W-1:0] mem_ff [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   logic [AW-1:0]      head_ff, head_in;
   logic [AW-1:0]      tail_ff, tail_in;
   logic [CW-1:0]      occ_ff, occ_in;
   logic               rev_ff, rev_in;
   logic [VALUE_W-1:0] key_ff;
   logic [AW-1:0]      scan_ff;
   logic [CW-1:0]      idx_ff;
   logic               found_ff;
   logic [CW-1:0]      pos_ff;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [AW-1:0]      front;
   logic               is_empty;
   logic               is_full;
   func_type           func;
   logic [XW-1:0]      count_wide;
   logic [XW-1:0]      pos_wide;

   logic [1:0]         rsp_status_ff;
   logic [VALUE_W-1:0] rsp_popped_ff;
   logic               rsp_found_ff;
   logic [FIELD_W-1:0] rsp_position_ff;
   logic [FIELD_W-1:0] rsp_count_ff;
   logic               rsp_is_full_ff;
   logic               rsp_is_empty_ff;

   function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
      return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
   endfunction

   function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
      return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
   endfunction

   assign func     = func_type'(req_func);
   assign is_empty = (occ_ff == '0);
   assign is_full  = (occ_ff == CW'(DEPTH));
   assign front    = rev_ff ? tail_ff : head_ff;

   assign dp_status.empty = is_empty;
   assign dp_status.match = (rd_data_ff == key_ff);
   assign dp_status.last  = (idx_ff == occ_ff - CW'(1));

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      occ_in  = occ_ff;
      rev_in  = rev_ff;
      wr_en   = 1'b0;
      wr_addr = ptr_inc(tail_ff);
      rd_en   = 1'b0;
      rd_addr = front;
      if (dp_cmd.accept) begin
         unique case (func)
            FUNC_PUSH: begin
               if (!is_full) begin
                  wr_en  = 1'b1;
                  occ_in = occ_ff + CW'(1);
                  if (rev_ff) begin
                     head_in = ptr_dec(head_ff);
                     wr_addr = ptr_dec(head_ff);
                  end else begin
                     tail_in = ptr_inc(tail_ff);
                  end
               end
            end
            FUNC_POP: begin
               if (!is_empty) begin
                  rd_en  = 1'b1;
                  occ_in = occ_ff - CW'(1);
                  if (rev_ff) begin
                     tail_in = ptr_dec(tail_ff);
                  end else begin
                     head_in = ptr_inc(head_ff);
                  end
               end
            end
            FUNC_REVERSE: begin
               rev_in = !rev_ff;
            end
            FUNC_FIND: begin
               rd_en = dp_cmd.find_start;
            end
         endcase
      end else if (dp_cmd.scan_step) begin
         rd_en   = 1'b1;
         rd_addr = scan_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= req_value;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= AW'(DEPTH - 1);
         occ_ff  <= '0;
         rev_ff  <= 1'b0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         occ_ff  <= occ_in;
         rev_ff  <= rev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.find_start) begin
         key_ff  <= req_value;
         scan_ff <= rev_ff ? ptr_dec(front) : ptr_inc(front);
         idx_ff  <= '0;
      end else if (dp_cmd.scan_step) begin
         scan_ff <= rev_ff ? ptr_dec(scan_ff) : ptr_inc(scan_ff);
         idx_ff  <= idx_ff + CW'(1);
      end
      if (dp_cmd.find_end) begin
         found_ff <= dp_status.match;
         pos_ff   <= dp_status.match ? idx_ff + CW'(1) : '0;
      end
   end

   assign count_wide = XW'(occ_in);
   assign pos_wide   = XW'(pos_ff);

   always_ff @(posedge clock) begin
      if (dp_cmd.load_rsp) begin
         rsp_count_ff    <= count_wide[FIELD_W-1:0];
         rsp_is_full_ff  <= (occ_in == CW'(DEPTH));
         rsp_is_empty_ff <= (occ_in == '0);
         rsp_status_ff   <= STATUS_OK;
         rsp_popped_ff   <= '0;
         rsp_found_ff    <= 1'b0;
         rsp_position_ff <= '0;
         unique case (dp_cmd.rsp_sel)
            RSP_POP: begin
               rsp_popped_ff <= rd_data_ff;
            end
            RSP_FIND: begin
               rsp_found_ff    <= found_ff;
               rsp_position_ff <= pos_wide[FIELD_W-1:0];
            end
            default: begin
               priority if (func == FUNC_PUSH && is_full) begin
                  rsp_status_ff <= STATUS_FULL;
               end else if (func == FUNC_POP) begin
                  rsp_status_ff <= STATUS_EMPTY;
               end else begin
                  rsp_status_ff <= STATUS_OK;
               end
            end
         endcase
      end
   end

   assign rsp_status   = rsp_status_ff;
   assign rsp_popped   = rsp_popped_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_is_full  = rsp_is_full_ff;
   assign rsp_is_empty = rsp_is_empty_ff;

endmodule

/* hw/rtl/bounded_queue_reverse_find.sv */
// ----------------------------------------------------------------------------
// Bounded queue with reverse and find
// Channel  | Direction | Handshake            | Word
// req      | in        | req_valid/req_stall  | func, value
// rsp      | out       | rsp_valid/rsp_stall  | status, popped, found, position,
//          |           |                      | count, is_full, is_empty
// Push, reverse, and pop or find on an empty queue load the result on acceptance.
// Pop loads the result from ST_POP, after the registered read of the entry memory.
// Find walks ST_SCAN to the match or, on a miss, to the last entry, then ST_FIND_DONE;
// the single read port lets the scan walk one entry per cycle.
// Reset is synchronous and empties the queue; the entry memory is not cleared.
// A stalled result holds in the output register and blocks the next request.
// ----------------------------------------------------------------------------
`include "bounded_queue_reverse_find_macros.svh"

module bounded_queue_reverse_find #(
   parameter int DEPTH = bqrf_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_func,
   input  logic signed [bqrf_pkg::VALUE_W-1:0] req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic signed [bqrf_pkg::VALUE_W-1:0] rsp_popped,
   output logic                                rsp_found,
   output logic [bqrf_pkg::FIELD_W-1:0]        rsp_position,
   output logic [bqrf_pkg::FIELD_W-1:0]        rsp_count,
   output logic                                rsp_is_full,
   output logic                                rsp_is_empty
);
   import bqrf_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   bqrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   bqrf_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_func     (req_func),
      .req_value    (req_value),
      .dp_cmd       (dp_cmd),
      .dp_status    (dp_status),
      .rsp_status   (rsp_status),
      .rsp_popped   (rsp_popped),
      .rsp_found    (rsp_found),
      .rsp_position (rsp_position),
      .rsp_count    (rsp_count),
      .rsp_is_full  (rsp_is_full),
      .rsp_is_empty (rsp_is_empty)
   );

   `BQRF_ASSERT_IMPLY(a_full_status, clock, reset, rsp_valid && rsp_status == STATUS_FULL, rsp_is_full && !rsp_is_empty)
   `BQRF_ASSERT_IMPLY(a_empty_status, clock, reset, rsp_valid && rsp_status == STATUS_EMPTY, rsp_is_empty && rsp_popped == '0)
   `BQRF_ASSERT_IMPLY(a_miss_position, clock, reset, rsp_valid && !rsp_found, rsp_position == '0)
   `BQRF_ASSERT_NEXT(a_pop_takes_two, clock, reset, req_valid && !req_stall && req_func == FUNC_POP && !rsp_is_empty && rsp_valid, req_stall)

endmodule
